### sv/slot_map_table_assert.svh
// ----------------------------------------------------------------------------
// Slot map table assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SLOT_MAP_TABLE_ASSERT_SVH
`define SLOT_MAP_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SMT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot_map_table check failed");

// next-cycle implication
`define SMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot_map_table check failed");

`else

`define SMT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### sv/smt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot map table package
// Shared widths, operation and status codes, and the result record.
// ----------------------------------------------------------------------------
package smt_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int COL_WIDTH_DEF = 32;

    localparam int FUNC_W   = 3;
    localparam int HANDLE_W = 10;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT    = 3'd0,
        FN_ERASE_HDL = 3'd1,
        FN_ERASE_POS = 3'd2,
        FN_LOOKUP    = 3'd3,
        FN_PRESENT   = 3'd4,
        FN_READ_POS  = 3'd5
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_BAD_HANDLE = 2'd2,
        ST_BAD_POS    = 2'd3
    } t_status;

    typedef struct packed {
        t_status                    status;
        logic                       present;
        logic [HANDLE_W-1:0]        out_handle;
        logic signed [DATA_W-1:0]   out_a;
        logic signed [DATA_W-1:0]   out_b;
        logic signed [DATA_W-1:0]   out_c;
        logic signed [DATA_W-1:0]   out_d;
        logic [COUNT_W-1:0]         row_count;
    } t_result;

endpackage

### sv/smt_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot map table command channel
// Valid/ready channel carrying one operation and its operands.
// ----------------------------------------------------------------------------
interface smt_cmd_if import smt_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic [HANDLE_W-1:0]        handle;
    logic [HANDLE_W-1:0]        position;
    logic signed [DATA_W-1:0]   col_a;
    logic signed [DATA_W-1:0]   col_b;
    logic signed [DATA_W-1:0]   col_c;
    logic signed [DATA_W-1:0]   col_d;

    modport source (
        output valid, func, handle, position, col_a, col_b, col_c, col_d,
        input  ready
    );

    modport sink (
        input  valid, func, handle, position, col_a, col_b, col_c, col_d,
        output ready
    );

endinterface

### sv/smt_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot map table response channel
// Valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
interface smt_rsp_if import smt_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic                       present;
    logic [HANDLE_W-1:0]        out_handle;
    logic signed [DATA_W-1:0]   out_a;
    logic signed [DATA_W-1:0]   out_b;
    logic signed [DATA_W-1:0]   out_c;
    logic signed [DATA_W-1:0]   out_d;
    logic [COUNT_W-1:0]         row_count;

    modport source (
        output valid, status, present, out_handle, out_a, out_b, out_c, out_d,
               row_count,
        input  ready
    );

    modport sink (
        input  valid, status, present, out_handle, out_a, out_b, out_c, out_d,
               row_count,
        output ready
    );

endinterface

### sv/smt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot map table RAM
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module smt_ram import smt_pkg::*; #(
    parameter int WIDTH = COL_WIDTH_DEF,
    parameter int DEPTH = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/smt_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot map table sequencer
// Reads, checks and writes back the handle index and row memories.
// ----------------------------------------------------------------------------
module smt_seq import smt_pkg::*; #(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int COL_WIDTH = COL_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    smt_cmd_if.sink                                cmd,
    output t_result                                o_res,
    output logic                                   o_res_valid,
    input  logic                                   i_res_ready,
    // handle index memory
    output logic                                   o_hm_we,
    output logic [$clog2(CAPACITY)-1:0]            o_hm_waddr,
    output logic [$clog2(CAPACITY+1)-1:0]          o_hm_wdata,
    output logic [$clog2(CAPACITY)-1:0]            o_hm_raddr,
    input  logic [$clog2(CAPACITY+1)-1:0]          i_hm_rdata,
    // row memory: owner handle over four columns
    output logic                                   o_pm_we,
    output logic [$clog2(CAPACITY)-1:0]            o_pm_waddr,
    output logic [$clog2(CAPACITY)+4*COL_WIDTH-1:0] o_pm_wdata,
    output logic [$clog2(CAPACITY)-1:0]            o_pm_raddr,
    input  logic [$clog2(CAPACITY)+4*COL_WIDTH-1:0] i_pm_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > HANDLE_W) ? CW : HANDLE_W;
    localparam int RW = AW + 4 * COL_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_CHECK,
        S_MOVE,
        S_FREE,
        S_RESP
    } t_state;

    t_state                  r_state, n_state;
    t_func                   r_func, n_func;
    logic [HANDLE_W-1:0]     r_hdl_in, n_hdl_in;
    logic [HANDLE_W-1:0]     r_pos_in, n_pos_in;
    logic [4*COL_WIDTH-1:0]  r_cols, n_cols;
    logic [CW-1:0]           r_free_head, n_free_head;
    logic [CW-1:0]           r_issued, n_issued;
    logic [CW-1:0]           r_live, n_live;
    logic [AW-1:0]           r_pos, n_pos;
    logic [AW-1:0]           r_hdl, n_hdl;
    t_result                 r_res, n_res;

    logic                    w_accept;
    logic [CW-1:0]           w_last;
    logic [AW-1:0]           w_owner;
    logic                    w_pos_ok;
    logic                    w_hdl_ok;
    logic                    w_match;
    logic                    w_free_empty;
    logic [DATA_W-1:0]       w_col [4];

    assign cmd.ready    = (r_state == S_IDLE) && i_rst_n;
    assign w_accept     = cmd.valid && cmd.ready;
    assign w_last       = r_live - CW'(1);
    assign w_owner      = i_pm_rdata[RW-1 -: AW];
    assign w_pos_ok     = XW'(r_pos_in) < XW'(r_live);
    assign w_hdl_ok     = (XW'(r_hdl_in) < XW'(r_issued)) && (i_hm_rdata < r_live);
    assign w_match      = XW'(w_owner) == XW'(r_hdl_in);
    assign w_free_empty = r_free_head == r_issued;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_col[k] = DATA_W'(i_pm_rdata[k*COL_WIDTH +: COL_WIDTH]);
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = (r_state == S_RESP);

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_hdl_in    = r_hdl_in;
        n_pos_in    = r_pos_in;
        n_cols      = r_cols;
        n_free_head = r_free_head;
        n_issued    = r_issued;
        n_live      = r_live;
        n_pos       = r_pos;
        n_hdl       = r_hdl;
        n_res       = r_res;

        o_hm_we    = 1'b0;
        o_hm_waddr = AW'(r_free_head);
        o_hm_wdata = r_live;
        o_hm_raddr = (t_func'(cmd.func) == FN_INSERT) ? AW'(r_free_head) : AW'(cmd.handle);
        o_pm_we    = 1'b0;
        o_pm_waddr = AW'(r_live);
        o_pm_wdata = {AW'(r_free_head), r_cols};
        o_pm_raddr = AW'(cmd.position);

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_func   = t_func'(cmd.func);
                    n_hdl_in = cmd.handle;
                    n_pos_in = cmd.position;
                    n_cols   = {COL_WIDTH'(cmd.col_d), COL_WIDTH'(cmd.col_c),
                                COL_WIDTH'(cmd.col_b), COL_WIDTH'(cmd.col_a)};
                    n_state  = S_LOOK;
                end
            end

            S_LOOK: begin
                n_res           = '0;
                n_res.status    = ST_OK;
                n_res.row_count = COUNT_W'(r_live);
                n_state         = S_RESP;
                unique case (r_func) inside
                    FN_INSERT: begin
                        if (r_live == CW'(CAPACITY)) begin
                            n_res.status = ST_FULL;
                        end else begin
                            o_hm_we          = 1'b1;
                            o_pm_we          = 1'b1;
                            n_free_head      = w_free_empty ? r_issued + CW'(1) : i_hm_rdata;
                            n_issued         = w_free_empty ? r_issued + CW'(1) : r_issued;
                            n_live           = r_live + CW'(1);
                            n_res.present    = 1'b1;
                            n_res.out_handle = HANDLE_W'(AW'(r_free_head));
                            n_res.row_count  = COUNT_W'(r_live + CW'(1));
                        end
                    end
                    FN_READ_POS: begin
                        if (w_pos_ok) begin
                            n_res.present    = 1'b1;
                            n_res.out_handle = HANDLE_W'(w_owner);
                            n_res.out_a      = w_col[0];
                            n_res.out_b      = w_col[1];
                            n_res.out_c      = w_col[2];
                            n_res.out_d      = w_col[3];
                        end else begin
                            n_res.status = ST_BAD_POS;
                        end
                    end
                    FN_ERASE_POS: begin
                        if (w_pos_ok) begin
                            o_pm_raddr = AW'(w_last);
                            n_pos      = AW'(r_pos_in);
                            n_hdl      = w_owner;
                            n_state    = S_MOVE;
                        end else begin
                            n_res.status = ST_BAD_POS;
                        end
                    end
                    FN_ERASE_HDL, FN_LOOKUP, FN_PRESENT: begin
                        if (w_hdl_ok) begin
                            o_pm_raddr = AW'(i_hm_rdata);
                            n_pos      = AW'(i_hm_rdata);
                            n_hdl      = AW'(r_hdl_in);
                            n_state    = S_CHECK;
                        end else if (r_func != FN_PRESENT) begin
                            n_res.status = ST_BAD_HANDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_CHECK: begin
                n_state = S_RESP;
                if (!w_match) begin
                    if (r_func != FN_PRESENT) begin
                        n_res.status = ST_BAD_HANDLE;
                    end
                end else begin
                    unique case (r_func) inside
                        FN_LOOKUP: begin
                            n_res.present = 1'b1;
                            n_res.out_a   = w_col[0];
                            n_res.out_b   = w_col[1];
                            n_res.out_c   = w_col[2];
                            n_res.out_d   = w_col[3];
                        end
                        FN_PRESENT: begin
                            n_res.present = 1'b1;
                        end
                        FN_ERASE_HDL: begin
                            o_pm_raddr = AW'(w_last);
                            n_state    = S_MOVE;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_MOVE: begin
                // move the last row into the hole and repoint its handle
                o_pm_we    = 1'b1;
                o_pm_waddr = r_pos;
                o_pm_wdata = i_pm_rdata;
                o_hm_we    = 1'b1;
                o_hm_waddr = w_owner;
                o_hm_wdata = CW'(r_pos);
                n_state    = S_FREE;
            end

            S_FREE: begin
                // push the erased handle onto the free list
                o_hm_we         = 1'b1;
                o_hm_waddr      = r_hdl;
                o_hm_wdata      = r_free_head;
                n_free_head     = CW'(r_hdl);
                n_live          = w_last;
                n_res           = '0;
                n_res.status    = ST_OK;
                n_res.row_count = COUNT_W'(w_last);
                n_state         = S_RESP;
            end

            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_issued    <= '0;
            r_live      <= '0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_issued    <= n_issued;
            r_live      <= n_live;
        end
        r_func   <= n_func;
        r_hdl_in <= n_hdl_in;
        r_pos_in <= n_pos_in;
        r_cols   <= n_cols;
        r_pos    <= n_pos;
        r_hdl    <= n_hdl;
        r_res    <= n_res;
    end

endmodule

### sv/slot_map_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot map table
// Densely packed four-column rows addressed by stable handles.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one operation per transfer: insert, erase by handle, erase
//   by position, lookup, presence test or read by position. o_rsp returns
//   exactly one result per command, in order.
//   The sequencer works on one command at a time. Each step accesses the
//   handle index memory, the row memory or both, each with a registered read.
//   Insert, read by position, unused codes, and any command whose handle or
//   position fails the range check take only the lookup step; lookup,
//   presence test, and a handle that fails the owner check add an owner
//   check; erase by position adds a row move and a free-list push; erase by
//   handle adds the owner check, move and push. The result lands in an output
//   register as the sequencer returns to idle for the next command. A new
//   command is accepted while that register still waits; if the receiver
//   stalls, the following result holds in the sequencer and i_cmd stays not
//   ready until the register frees. Reset clears the counts and free list; no
//   memory clearing is needed, so the block is ready once reset is released.
// ----------------------------------------------------------------------------
`include "slot_map_table_assert.svh"

module slot_map_table import smt_pkg::*; #(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int COL_WIDTH = COL_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smt_cmd_if.sink   i_cmd,
    smt_rsp_if.source o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = AW + 4 * COL_WIDTH;

    t_result          w_res;
    logic             w_res_valid;
    logic             w_res_ready;

    logic             w_hm_we;
    logic [AW-1:0]    w_hm_waddr;
    logic [CW-1:0]    w_hm_wdata;
    logic [AW-1:0]    w_hm_raddr;
    logic [CW-1:0]    w_hm_rdata;

    logic             w_pm_we;
    logic [AW-1:0]    w_pm_waddr;
    logic [RW-1:0]    w_pm_wdata;
    logic [AW-1:0]    w_pm_raddr;
    logic [RW-1:0]    w_pm_rdata;

    logic             r_out_valid, n_out_valid;
    t_result          r_out;

    smt_seq #(
        .CAPACITY  (CAPACITY),
        .COL_WIDTH (COL_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .cmd         (i_cmd),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_hm_we     (w_hm_we),
        .o_hm_waddr  (w_hm_waddr),
        .o_hm_wdata  (w_hm_wdata),
        .o_hm_raddr  (w_hm_raddr),
        .i_hm_rdata  (w_hm_rdata),
        .o_pm_we     (w_pm_we),
        .o_pm_waddr  (w_pm_waddr),
        .o_pm_wdata  (w_pm_wdata),
        .o_pm_raddr  (w_pm_raddr),
        .i_pm_rdata  (w_pm_rdata)
    );

    smt_ram #(
        .WIDTH (CW),
        .DEPTH (CAPACITY)
    ) u_hdl_mem (
        .i_clk   (i_clk),
        .i_we    (w_hm_we),
        .i_waddr (w_hm_waddr),
        .i_wdata (w_hm_wdata),
        .i_raddr (w_hm_raddr),
        .o_rdata (w_hm_rdata)
    );

    smt_ram #(
        .WIDTH (RW),
        .DEPTH (CAPACITY)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_we    (w_pm_we),
        .i_waddr (w_pm_waddr),
        .i_wdata (w_pm_wdata),
        .i_raddr (w_pm_raddr),
        .o_rdata (w_pm_rdata)
    );

    assign w_res_ready = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_res_valid && w_res_ready) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.present    = r_out.present;
    assign o_rsp.out_handle = r_out.out_handle;
    assign o_rsp.out_a      = r_out.out_a;
    assign o_rsp.out_b      = r_out.out_b;
    assign o_rsp.out_c      = r_out.out_c;
    assign o_rsp.out_d      = r_out.out_d;
    assign o_rsp.row_count  = r_out.row_count;

    `SMT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready, !i_cmd.ready)
    `SMT_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, w_res_valid && w_res_ready, r_out_valid)
    `SMT_ASSERT_IMPL(a_present_is_ok, i_clk, i_rst_n, r_out_valid && r_out.present, r_out.status == ST_OK)
    `SMT_ASSERT_IMPL(a_no_accept_pending, i_clk, i_rst_n, w_res_valid, !i_cmd.ready)

endmodule

### tb/sv/slot_map_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot map table testbench
// Drives commands through the valid/ready command channel, models the table
// (rows, handle index, reverse map, free list) alongside the block, and checks
// every reply field in order. Covers empty-table errors, stale handles,
// handle reuse, a full table, and long random traffic under varied stalls.
// ----------------------------------------------------------------------------
module slot_map_table_tb;
    import smt_pkg::*;

    localparam int CAP         = CAPACITY_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 100;
    localparam int ERASE_ROWS  = 128;

    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    typedef struct {
        logic [FUNC_W-1:0]        func;
        logic [HANDLE_W-1:0]      handle;
        logic [HANDLE_W-1:0]      position;
        logic signed [DATA_W-1:0] col_a;
        logic signed [DATA_W-1:0] col_b;
        logic signed [DATA_W-1:0] col_c;
        logic signed [DATA_W-1:0] col_d;
    } t_op;

    typedef struct packed {
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic signed [DATA_W-1:0] c;
        logic signed [DATA_W-1:0] d;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    smt_cmd_if cmd_ch ();
    smt_rsp_if rsp_ch ();

    slot_map_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    t_row                row_mem [CAP];
    logic [COUNT_W-1:0]  hdl_pos [CAP];
    logic [HANDLE_W-1:0] pos_hdl [CAP];
    logic [COUNT_W-1:0]  free_head;
    logic [COUNT_W-1:0]  issued;
    logic [COUNT_W-1:0]  live;

    t_result awaited_replies [$];
    int      mismatch_cnt;
    int      idle_cycles;
    int      src_gap_pct;
    int      snk_stall_pct;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------------
    function automatic bit handle_is_live(input logic [HANDLE_W-1:0] h);
        logic [COUNT_W-1:0] p;
        if ({1'b0, h} >= issued) return 1'b0;
        p = hdl_pos[h];
        if (p >= live) return 1'b0;
        return pos_hdl[p[HANDLE_W-1:0]] == h;
    endfunction

    function automatic void drop_row(input logic [HANDLE_W-1:0] p);
        logic [HANDLE_W-1:0] h;
        logic [HANDLE_W-1:0] last;
        h    = pos_hdl[p];
        last = HANDLE_W'(live - 1);
        if (p != last) begin
            row_mem[p]          = row_mem[last];
            pos_hdl[p]          = pos_hdl[last];
            hdl_pos[pos_hdl[p]] = {1'b0, p};
        end
        live       = live - COUNT_W'(1);
        hdl_pos[h] = free_head;
        free_head  = {1'b0, h};
    endfunction

    function automatic t_result table_apply(input t_op op);
        t_result             r;
        logic [COUNT_W-1:0]  nh;
        logic [HANDLE_W-1:0] p;
        r = '0;
        case (op.func)
            FN_INSERT: begin
                if (live >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    p = live[HANDLE_W-1:0];
                    if (free_head == issued) begin
                        nh        = issued;
                        issued    = issued + COUNT_W'(1);
                        free_head = issued;
                    end else begin
                        nh        = free_head;
                        free_head = hdl_pos[nh[HANDLE_W-1:0]];
                    end
                    hdl_pos[nh[HANDLE_W-1:0]] = {1'b0, p};
                    pos_hdl[p]   = nh[HANDLE_W-1:0];
                    row_mem[p]   = '{op.col_a, op.col_b, op.col_c, op.col_d};
                    live         = live + COUNT_W'(1);
                    r.out_handle = nh[HANDLE_W-1:0];
                    r.present    = 1'b1;
                end
            end
            FN_ERASE_HDL: begin
                if (!handle_is_live(op.handle)) r.status = ST_BAD_HANDLE;
                else drop_row(hdl_pos[op.handle][HANDLE_W-1:0]);
            end
            FN_ERASE_POS: begin
                if ({1'b0, op.position} >= live) r.status = ST_BAD_POS;
                else drop_row(op.position);
            end
            FN_LOOKUP: begin
                if (!handle_is_live(op.handle)) begin
                    r.status = ST_BAD_HANDLE;
                end else begin
                    p         = hdl_pos[op.handle][HANDLE_W-1:0];
                    r.out_a   = row_mem[p].a;
                    r.out_b   = row_mem[p].b;
                    r.out_c   = row_mem[p].c;
                    r.out_d   = row_mem[p].d;
                    r.present = 1'b1;
                end
            end
            FN_PRESENT: begin
                r.present = handle_is_live(op.handle);
            end
            FN_READ_POS: begin
                if ({1'b0, op.position} >= live) begin
                    r.status = ST_BAD_POS;
                end else begin
                    r.out_a      = row_mem[op.position].a;
                    r.out_b      = row_mem[op.position].b;
                    r.out_c      = row_mem[op.position].c;
                    r.out_d      = row_mem[op.position].d;
                    r.out_handle = pos_hdl[op.position];
                    r.present    = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.row_count = live;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Command generation
    // ------------------------------------------------------------------------
    function automatic t_op make_cmd(
        input logic [FUNC_W-1:0]        func,
        input logic [HANDLE_W-1:0]      handle,
        input logic [HANDLE_W-1:0]      position,
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b,
        input logic signed [DATA_W-1:0] c,
        input logic signed [DATA_W-1:0] d
    );
        t_op op;
        op.func     = func;
        op.handle   = handle;
        op.position = position;
        op.col_a    = a;
        op.col_b    = b;
        op.col_c    = c;
        op.col_d    = d;
        return op;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_col();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_handle();
        int k;
        k = $urandom_range(99);
        if (k < 70 && live != 0) return pos_hdl[$urandom_range(live - 1)];
        if (k < 85 && free_head != issued) return free_head[HANDLE_W-1:0];
        if (k < 92 && issued != 0) return HANDLE_W'($urandom_range(issued - 1));
        return HANDLE_W'($urandom_range(CAP - 1));
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_position();
        int k;
        k = $urandom_range(99);
        if (k < 75 && live != 0) return HANDLE_W'($urandom_range(live - 1));
        if (k < 85) return live[HANDLE_W-1:0];
        return HANDLE_W'($urandom_range(CAP - 1));
    endfunction

    function automatic t_op random_op(input int target);
        t_op op;
        int  k;
        op = make_cmd(FN_LOOKUP, pick_handle(), pick_position(),
                      rand_col(), rand_col(), rand_col(), rand_col());
        k = $urandom_range(99);
        if (k < ((live < target) ? 45 : 12)) begin
            op.func = FN_INSERT;
        end else begin
            k = $urandom_range(49);
            if (k < 10)       op.func = FN_ERASE_HDL;
            else if (k < 20)  op.func = FN_ERASE_POS;
            else if (k < 30)  op.func = FN_LOOKUP;
            else if (k < 38)  op.func = FN_PRESENT;
            else if (k < 48)  op.func = FN_READ_POS;
            else if (k == 48) op.func = FN_SPARE_LO;
            else              op.func = FN_SPARE_HI;
        end
        return op;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------
    task automatic issue_op(input t_op op);
        while ($urandom_range(99) < src_gap_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.func     <= op.func;
        cmd_ch.handle   <= op.handle;
        cmd_ch.position <= op.position;
        cmd_ch.col_a    <= op.col_a;
        cmd_ch.col_b    <= op.col_b;
        cmd_ch.col_c    <= op.col_c;
        cmd_ch.col_d    <= op.col_d;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        awaited_replies.insert(awaited_replies.size(), table_apply(op));
    endtask

    task automatic drain_replies();
        cmd_ch.valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Reply checking and watchdog
    // ------------------------------------------------------------------------
    task automatic flag_field(input string fld, input logic [63:0] want,
                              input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, fld, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : check_replies
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_replies.size() == 0) begin
                $display("%0t: reply with none outstanding, expected none actual row_count %0d",
                         $time, rsp_ch.row_count);
                mismatch_cnt++;
            end else begin
                want = awaited_replies.pop_front();
                flag_field("status",     64'(want.status),     64'(rsp_ch.status));
                flag_field("present",    64'(want.present),    64'(rsp_ch.present));
                flag_field("out_handle", 64'(want.out_handle), 64'(rsp_ch.out_handle));
                flag_field("out_a",      64'(want.out_a),      64'(rsp_ch.out_a));
                flag_field("out_b",      64'(want.out_b),      64'(rsp_ch.out_b));
                flag_field("out_c",      64'(want.out_c),      64'(rsp_ch.out_c));
                flag_field("out_d",      64'(want.out_d),      64'(rsp_ch.out_d));
                flag_field("row_count",  64'(want.row_count),  64'(rsp_ch.row_count));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_empty_table_and_reuse();
        issue_op(make_cmd(FN_LOOKUP,    0, 0, 0, 0, 0, 0));
        issue_op(make_cmd(FN_PRESENT,   0, 0, 0, 0, 0, 0));
        issue_op(make_cmd(FN_READ_POS,  0, 0, 0, 0, 0, 0));
        issue_op(make_cmd(FN_ERASE_POS, 0, 0, 0, 0, 0, 0));
        issue_op(make_cmd(FN_ERASE_HDL, 0, 0, 0, 0, 0, 0));
        issue_op(make_cmd(FN_SPARE_LO, 10'h3FF, 10'h3FF, -1, -1, -1, -1));
        issue_op(make_cmd(FN_SPARE_HI, 10'h155, 10'h2AA, 0, 0, 0, 0));
        issue_op(make_cmd(FN_INSERT, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, -1));
        issue_op(make_cmd(FN_INSERT, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, -1, 0));
        issue_op(make_cmd(FN_INSERT, 0, 0, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'h0F0F_0F0F, 32'hF0F0_F0F0));
        issue_op(make_cmd(FN_LOOKUP,    1, 0, 0, 0, 0, 0));
        issue_op(make_cmd(FN_PRESENT,   2, 0, 0, 0, 0, 0));
        issue_op(make_cmd(FN_READ_POS,  0, 2, 0, 0, 0, 0));
        issue_op(make_cmd(FN_READ_POS,  0, 3, 0, 0, 0, 0));
        issue_op(make_cmd(FN_ERASE_HDL, 0, 0, 0, 0, 0, 0));
        issue_op(make_cmd(FN_LOOKUP,    0, 0, 0, 0, 0, 0));
        issue_op(make_cmd(FN_PRESENT,   0, 0, 0, 0, 0, 0));
        issue_op(make_cmd(FN_READ_POS,  0, 0, 0, 0, 0, 0));
        issue_op(make_cmd(FN_INSERT, 0, 0, 1, 2, 3, 4));
        issue_op(make_cmd(FN_ERASE_POS, 0, 2, 0, 0, 0, 0));
        issue_op(make_cmd(FN_ERASE_POS, 0, 0, 0, 0, 0, 0));
        issue_op(make_cmd(FN_LOOKUP,    10'h3FF, 0, 0, 0, 0, 0));
        issue_op(make_cmd(FN_READ_POS,  0, 10'h3FF, 0, 0, 0, 0));
        issue_op(make_cmd(FN_PRESENT,   1, 0, 0, 0, 0, 0));
        issue_op(make_cmd(FN_ERASE_HDL, 1, 0, 0, 0, 0, 0));
    endtask

    task automatic test_table_full();
        while (live < CAP) begin
            issue_op(make_cmd(FN_INSERT, pick_handle(), pick_position(),
                              rand_col(), rand_col(), rand_col(), rand_col()));
        end
        issue_op(make_cmd(FN_INSERT, 0, 0, rand_col(), rand_col(), rand_col(), rand_col()));
        issue_op(make_cmd(FN_READ_POS, 0, HANDLE_W'(CAP - 1), 0, 0, 0, 0));
        issue_op(make_cmd(FN_LOOKUP, HANDLE_W'(CAP - 1), 0, 0, 0, 0, 0));
        issue_op(make_cmd(FN_PRESENT, pick_handle(), 0, 0, 0, 0, 0));
        issue_op(make_cmd(FN_READ_POS, 0, pick_position(), 0, 0, 0, 0));
        while (live > CAP - ERASE_ROWS) begin
            if ($urandom_range(1))
                issue_op(make_cmd(FN_ERASE_HDL, pos_hdl[$urandom_range(live - 1)], 0,
                                  0, 0, 0, 0));
            else
                issue_op(make_cmd(FN_ERASE_POS, 0, HANDLE_W'($urandom_range(live - 1)),
                                  0, 0, 0, 0));
        end
    endtask

    task automatic test_random_traffic();
        int target;
        target = 0;
        for (int phase = 0; phase < 3; phase++) begin
            drain_replies();
            case (phase)
                0: begin
                    src_gap_pct   = 25;
                    snk_stall_pct = 64;
                end
                1: begin
                    src_gap_pct   = 64;
                    snk_stall_pct = 25;
                end
                default: begin
                    src_gap_pct   = 0;
                    snk_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 100 == 0) begin
                    case ($urandom_range(3))
                        0:       target = 0;
                        1:       target = 6;
                        2:       target = 40;
                        default: target = 150;
                    endcase
                end
                issue_op(random_op(target));
            end
        end
    endtask

    initial begin
        mismatch_cnt    = 0;
        src_gap_pct     = 25;
        snk_stall_pct   = 64;
        free_head       = '0;
        issued          = '0;
        live            = '0;
        i_rst_n         <= 1'b0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.func     <= '0;
        cmd_ch.handle   <= '0;
        cmd_ch.position <= '0;
        cmd_ch.col_a    <= '0;
        cmd_ch.col_b    <= '0;
        cmd_ch.col_c    <= '0;
        cmd_ch.col_d    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table_and_reuse();
        drain_replies();
        test_table_full();
        test_random_traffic();

        drain_replies();
        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/smt_pkg.sv
sv/smt_cmd_if.sv
sv/smt_rsp_if.sv
sv/smt_ram.sv
sv/smt_seq.sv
sv/slot_map_table.sv
tb/sv/slot_map_table_tb.sv
